// ----- rtl/mva_pkg.sv -----
`timescale 1ns / 1ps

package mva_pkg;

   // default sizes
   localparam int MAX_VOICES_DEF       = 8;
   localparam int NOTE_STACK_DEPTH_DEF = 16;

   // field widths
   localparam int VOICE_COUNT_W = 4;
   localparam int OPCODE_W      = 2;
   localparam int NOTE_W        = 7;
   localparam int BEND_W        = 14;
   localparam int MASK_W        = 8;
   localparam int VIDX_W        = 3;
   localparam int VNOTE_W       = 8;
   localparam int REQ_TDATA_W   = 24;
   localparam int RSP_TDATA_W   = 56;

   localparam logic [BEND_W-1:0]        BEND_CENTRE  = 14'd8192;
   localparam logic [VNOTE_W-1:0]       SILENT_NOTE  = 8'hFF;
   localparam logic [VOICE_COUNT_W-1:0] VOICE_COUNT_RESET = 4'd1;

   typedef enum logic [OPCODE_W-1:0] {
      OP_NOTE_ON     = 2'd0,
      OP_NOTE_OFF    = 2'd1,
      OP_ALL_OFF     = 2'd2,
      OP_PITCH_WHEEL = 2'd3
   } opcode_type;

   typedef enum logic [4:0] {
      DP_NONE,
      DP_LOAD,
      DP_BCAST,
      DP_REDUCE,
      DP_SCAN_NEXT,
      DP_RR_HIT,
      DP_MISS,
      DP_POLY_SET,
      DP_PUSH,
      DP_SRCH_RD,
      DP_SP_INC,
      DP_V0_MISS,
      DP_SH_RD,
      DP_SH_WR,
      DP_POP,
      DP_TOP_RD,
      DP_TOP_EMPTY,
      DP_TOP_SET,
      DP_V0_COMMIT,
      DP_OUT
   } dp_action_type;

   typedef struct packed {
      dp_action_type action;
   } mva_cmd_type;

   typedef struct packed {
      opcode_type op;
      logic       mono;
      logic       idx_ge_nv;
      logic       scan_silent;
      logic       scan_match;
      logic       scan_last;
      logic       sel_zero;
      logic       stack_empty;
      logic       rd_match;
      logic       srch_last;
      logic       shift_more;
   } mva_status_type;

endpackage

// ----- rtl/midi_voice_allocator_unit.sv -----
`timescale 1ns / 1ps
// path from input transfer to rsp_tvalid: all notes off and pitch wheel go through dispatch and broadcast;
//   mono note on pushes onto the stack and commits voice 0; polyphonic note on reduces the pointer,
//   scans the voices and sets the voice it finds or reports a miss; a hit on voice 0 runs the stack path
// mono note off: searches the stack entry by entry and moves the later entries down one place;
//   one event in flight, next input taken after the result loads
// reset (synchronous, active high): voice count 1, voices silent, stack empty, pointer 0, bend 8192

module midi_voice_allocator_unit #(
   parameter int MAX_VOICES       = mva_pkg::MAX_VOICES_DEF,
   parameter int NOTE_STACK_DEPTH = mva_pkg::NOTE_STACK_DEPTH_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [mva_pkg::VOICE_COUNT_W-1:0]   csr_wdata,    // voice_count
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [mva_pkg::REQ_TDATA_W-1:0]     req_tdata,    // note, bend
   input  logic [mva_pkg::OPCODE_W-1:0]        req_tuser,    // opcode
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // target_mask, trigger_mask, retune_mask, voice_index, voice_note, dropped, bend_out
   output logic [mva_pkg::RSP_TDATA_W-1:0]     rsp_tdata
);
   import mva_pkg::*;

   localparam int RSP_USED_W = 3 * MASK_W + VIDX_W + VNOTE_W + 1 + BEND_W;

   mva_cmd_type         cmd;
   mva_status_type      status;
   logic [MASK_W-1:0]   rsp_target;
   logic [MASK_W-1:0]   rsp_trigger;
   logic [MASK_W-1:0]   rsp_retune;
   logic [VIDX_W-1:0]   rsp_voice_index;
   logic [VNOTE_W-1:0]  rsp_voice_note;
   logic                rsp_dropped;
   logic [BEND_W-1:0]   rsp_bend_out;

   assign csr_ready = 1'b1;

   mva_controller u_controller (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_tvalid),
      .req_ready (req_tready),
      .rsp_valid (rsp_tvalid),
      .rsp_ready (rsp_tready),
      .status    (status),
      .cmd       (cmd)
   );

   mva_datapath #(
      .MAX_VOICES       (MAX_VOICES),
      .NOTE_STACK_DEPTH (NOTE_STACK_DEPTH)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .status          (status),
      .csr_valid       (csr_valid),
      .csr_wdata       (csr_wdata),
      .req_opcode      (req_tuser),
      .req_note        (req_tdata[NOTE_W-1:0]),
      .req_bend        (req_tdata[NOTE_W+BEND_W-1:NOTE_W]),
      .out_target      (rsp_target),
      .out_trigger     (rsp_trigger),
      .out_retune      (rsp_retune),
      .out_voice_index (rsp_voice_index),
      .out_voice_note  (rsp_voice_note),
      .out_dropped     (rsp_dropped),
      .out_bend        (rsp_bend_out)
   );

   assign rsp_tdata = {{(RSP_TDATA_W - RSP_USED_W){1'b0}}, rsp_bend_out, rsp_dropped,
                       rsp_voice_note, rsp_voice_index, rsp_retune, rsp_trigger, rsp_target};

   // the block works on one event at a time
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("input taken while an event is still in work");

   a_trigger_retunes: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> ((rsp_trigger & ~rsp_retune) == '0))
      else $error("voice triggered without retune");

   a_trigger_targeted: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> ((rsp_trigger & ~rsp_target) == '0))
      else $error("voice triggered that did not receive the event");

endmodule

// ----- rtl/mva_datapath.sv -----
`timescale 1ns / 1ps

module mva_datapath #(
   parameter int MAX_VOICES       = mva_pkg::MAX_VOICES_DEF,
   parameter int NOTE_STACK_DEPTH = mva_pkg::NOTE_STACK_DEPTH_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  mva_pkg::mva_cmd_type                 cmd,
   output mva_pkg::mva_status_type              status,
   input  logic                                 csr_valid,
   input  logic [mva_pkg::VOICE_COUNT_W-1:0]    csr_wdata,
   input  logic [mva_pkg::OPCODE_W-1:0]         req_opcode,
   input  logic [mva_pkg::NOTE_W-1:0]           req_note,
   input  logic [mva_pkg::BEND_W-1:0]           req_bend,
   output logic [mva_pkg::MASK_W-1:0]           out_target,
   output logic [mva_pkg::MASK_W-1:0]           out_trigger,
   output logic [mva_pkg::MASK_W-1:0]           out_retune,
   output logic [mva_pkg::VIDX_W-1:0]           out_voice_index,
   output logic [mva_pkg::VNOTE_W-1:0]          out_voice_note,
   output logic                                 out_dropped,
   output logic [mva_pkg::BEND_W-1:0]           out_bend
);
   import mva_pkg::*;

   localparam int VW  = (MAX_VOICES > 1) ? $clog2(MAX_VOICES) : 1;
   localparam int NVW = $clog2(MAX_VOICES + 1);
   localparam int SW  = $clog2(NOTE_STACK_DEPTH);
   localparam int CW  = $clog2(NOTE_STACK_DEPTH + 1);

   logic [VOICE_COUNT_W-1:0] voice_count_ff, voice_count_in;
   logic [BEND_W-1:0]        bend_ff, bend_in;
   logic [VW-1:0]            ptr_ff, ptr_in;
   logic [CW-1:0]            count_ff, count_in;
   logic [VNOTE_W-1:0]       voice_note_ff [MAX_VOICES];
   logic [VNOTE_W-1:0]       voice_note_in [MAX_VOICES];

   opcode_type               op_ff, op_in;
   logic [NOTE_W-1:0]        note_ff, note_in;
   logic [VW-1:0]            idx_ff, idx_in;
   logic [NVW-1:0]           cnt_ff, cnt_in;
   logic [SW-1:0]            sp_ff, sp_in;
   logic [VNOTE_W-1:0]       top_ff, top_in;
   logic                     miss_ff, miss_in;

   logic [MASK_W-1:0]        res_target_ff, res_target_in;
   logic [MASK_W-1:0]        res_trigger_ff, res_trigger_in;
   logic [MASK_W-1:0]        res_retune_ff, res_retune_in;
   logic [VIDX_W-1:0]        res_vidx_ff, res_vidx_in;
   logic [VNOTE_W-1:0]       res_vnote_ff, res_vnote_in;
   logic                     res_dropped_ff, res_dropped_in;

   logic [MASK_W-1:0]        rsp_target_ff, rsp_trigger_ff, rsp_retune_ff;
   logic [VIDX_W-1:0]        rsp_vidx_ff;
   logic [VNOTE_W-1:0]       rsp_vnote_ff;
   logic                     rsp_dropped_ff;
   logic [BEND_W-1:0]        rsp_bend_ff;

   // voice 0 note stack
   logic [NOTE_W-1:0]        stack_mem [NOTE_STACK_DEPTH];
   logic [NOTE_W-1:0]        rdata_ff;
   logic                     mem_we, mem_re;
   logic [SW-1:0]            mem_waddr, mem_raddr;
   logic [NOTE_W-1:0]        mem_wdata;

   logic [NVW-1:0]           nv_eff;
   logic [NVW-1:0]           idx_ext;
   logic [VW-1:0]            idx_wrap_next;
   logic [NVW-1:0]           rr_start;
   logic [VW-1:0]            ptr_wrap_next;
   logic [CW-1:0]            sp_next_ext;
   logic [VNOTE_W-1:0]       cur_note;
   logic [VNOTE_W-1:0]       poly_note;
   logic [MAX_VOICES-1:0]    sel_mask;
   logic [MAX_VOICES-1:0]    bc_target;
   logic [MAX_VOICES-1:0]    bc_changed;
   logic                     v0_changed;

   // out-of-range counts clamp to one voice or to the voice limit
   always_comb begin
      if (voice_count_ff == '0) begin
         nv_eff = NVW'(1);
      end else if (int'(voice_count_ff) > MAX_VOICES) begin
         nv_eff = NVW'(MAX_VOICES);
      end else begin
         nv_eff = NVW'(voice_count_ff);
      end
   end

   assign idx_ext       = NVW'(idx_ff);
   assign idx_wrap_next = ((idx_ext + NVW'(1)) == nv_eff) ? '0 : VW'(idx_ext + NVW'(1));
   // reduced scan start, recovered from the current voice and the steps taken
   assign rr_start      = (idx_ext >= cnt_ff) ? (idx_ext - cnt_ff)
                                              : (idx_ext + nv_eff - cnt_ff);
   assign ptr_wrap_next = ((rr_start + NVW'(1)) == nv_eff) ? '0 : VW'(rr_start + NVW'(1));
   assign sp_next_ext   = CW'(sp_ff) + CW'(1);
   assign cur_note      = voice_note_ff[idx_ff];
   assign sel_mask      = MAX_VOICES'(1) << idx_ff;
   assign poly_note     = (op_ff == OP_NOTE_ON) ? {1'b0, note_ff} : SILENT_NOTE;
   assign v0_changed    = (top_ff != voice_note_ff[0]);

   always_comb begin
      for (int v = 0; v < MAX_VOICES; v++) begin
         bc_target[v]  = (v < int'(nv_eff));
         bc_changed[v] = bc_target[v] && (op_ff == OP_ALL_OFF) &&
                         (voice_note_ff[v] != SILENT_NOTE);
      end
   end

   always_comb begin
      status.op          = op_ff;
      status.mono        = (nv_eff == NVW'(1));
      status.idx_ge_nv   = (idx_ext >= nv_eff);
      status.scan_silent = (cur_note == SILENT_NOTE);
      status.scan_match  = (cur_note == {1'b0, note_ff});
      status.scan_last   = ((cnt_ff + NVW'(1)) == nv_eff);
      status.sel_zero    = (idx_ff == '0);
      status.stack_empty = (count_ff == '0);
      status.rd_match    = (rdata_ff == note_ff);
      status.srch_last   = (sp_next_ext == count_ff);
      status.shift_more  = (sp_next_ext < count_ff);
   end

   always_comb begin
      voice_count_in = csr_valid ? csr_wdata : voice_count_ff;
      bend_in        = bend_ff;
      ptr_in         = ptr_ff;
      count_in       = count_ff;
      voice_note_in  = voice_note_ff;
      op_in          = op_ff;
      note_in        = note_ff;
      idx_in         = idx_ff;
      cnt_in         = cnt_ff;
      sp_in          = sp_ff;
      top_in         = top_ff;
      miss_in        = miss_ff;
      res_target_in  = res_target_ff;
      res_trigger_in = res_trigger_ff;
      res_retune_in  = res_retune_ff;
      res_vidx_in    = res_vidx_ff;
      res_vnote_in   = res_vnote_ff;
      res_dropped_in = res_dropped_ff;
      mem_we         = 1'b0;
      mem_re         = 1'b0;
      mem_waddr      = sp_ff;
      mem_raddr      = sp_ff;
      mem_wdata      = rdata_ff;

      unique case (cmd.action)
         DP_LOAD: begin
            op_in   = opcode_type'(req_opcode);
            note_in = req_note;
            if (opcode_type'(req_opcode) == OP_PITCH_WHEEL) begin
               bend_in = req_bend;
            end
            // round-robin search starts at the pointer
            idx_in         = (opcode_type'(req_opcode) == OP_NOTE_ON) ? ptr_ff : '0;
            cnt_in         = '0;
            sp_in          = '0;
            res_target_in  = '0;
            res_trigger_in = '0;
            res_retune_in  = '0;
            res_vidx_in    = '0;
            res_vnote_in   = SILENT_NOTE;
            res_dropped_in = 1'b0;
         end
         DP_BCAST: begin
            res_target_in  = MASK_W'(bc_target);
            res_trigger_in = MASK_W'(bc_changed);
            res_retune_in  = (op_ff == OP_PITCH_WHEEL) ? MASK_W'(bc_target)
                                                       : MASK_W'(bc_changed);
            if (op_ff == OP_ALL_OFF) begin
               count_in = '0;
               for (int v = 0; v < MAX_VOICES; v++) begin
                  if (bc_target[v]) begin
                     voice_note_in[v] = SILENT_NOTE;
                  end
               end
            end
         end
         DP_REDUCE: begin
            idx_in = VW'(idx_ext - nv_eff);
         end
         DP_SCAN_NEXT: begin
            idx_in = idx_wrap_next;
            cnt_in = cnt_ff + NVW'(1);
         end
         DP_RR_HIT: begin
            // pointer steps by one from where the scan began
            ptr_in = ptr_wrap_next;
         end
         DP_MISS: begin
            res_dropped_in = 1'b1;
         end
         DP_POLY_SET: begin
            voice_note_in[idx_ff] = poly_note;
            res_target_in  = MASK_W'(sel_mask);
            res_trigger_in = MASK_W'(sel_mask);
            res_retune_in  = MASK_W'(sel_mask);
            res_vidx_in    = VIDX_W'(idx_ff);
            res_vnote_in   = poly_note;
         end
         DP_PUSH: begin
            if (count_ff != CW'(NOTE_STACK_DEPTH)) begin
               mem_we    = 1'b1;
               mem_waddr = SW'(count_ff);
               mem_wdata = note_ff;
               count_in  = count_ff + CW'(1);
               top_in    = {1'b0, note_ff};
               miss_in   = 1'b0;
            end else begin
               top_in  = voice_note_ff[0];
               miss_in = 1'b1;
            end
         end
         DP_SRCH_RD: begin
            mem_re    = 1'b1;
            mem_raddr = sp_ff;
         end
         DP_SP_INC: begin
            sp_in = SW'(sp_next_ext);
         end
         DP_V0_MISS: begin
            top_in  = voice_note_ff[0];
            miss_in = 1'b1;
         end
         DP_SH_RD: begin
            mem_re    = 1'b1;
            mem_raddr = SW'(sp_next_ext);
         end
         DP_SH_WR: begin
            mem_we    = 1'b1;
            mem_waddr = sp_ff;
            mem_wdata = rdata_ff;
            sp_in     = SW'(sp_next_ext);
         end
         DP_POP: begin
            count_in = count_ff - CW'(1);
            miss_in  = 1'b0;
         end
         DP_TOP_RD: begin
            mem_re    = 1'b1;
            mem_raddr = SW'(count_ff - CW'(1));
         end
         DP_TOP_EMPTY: begin
            top_in = SILENT_NOTE;
         end
         DP_TOP_SET: begin
            top_in = {1'b0, rdata_ff};
         end
         DP_V0_COMMIT: begin
            voice_note_in[0] = top_ff;
            res_target_in    = MASK_W'(1);
            res_trigger_in   = MASK_W'(v0_changed);
            res_retune_in    = MASK_W'(v0_changed);
            res_vidx_in      = '0;
            res_vnote_in     = top_ff;
            res_dropped_in   = miss_ff;
         end
         DP_OUT, DP_NONE: begin
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         voice_count_ff <= VOICE_COUNT_RESET;
         bend_ff        <= BEND_CENTRE;
         ptr_ff         <= '0;
         count_ff       <= '0;
         for (int v = 0; v < MAX_VOICES; v++) begin
            voice_note_ff[v] <= SILENT_NOTE;
         end
      end else begin
         voice_count_ff <= voice_count_in;
         bend_ff        <= bend_in;
         ptr_ff         <= ptr_in;
         count_ff       <= count_in;
         voice_note_ff  <= voice_note_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff          <= op_in;
      note_ff        <= note_in;
      idx_ff         <= idx_in;
      cnt_ff         <= cnt_in;
      sp_ff          <= sp_in;
      top_ff         <= top_in;
      miss_ff        <= miss_in;
      res_target_ff  <= res_target_in;
      res_trigger_ff <= res_trigger_in;
      res_retune_ff  <= res_retune_in;
      res_vidx_ff    <= res_vidx_in;
      res_vnote_ff   <= res_vnote_in;
      res_dropped_ff <= res_dropped_in;
      if (cmd.action == DP_OUT) begin
         rsp_target_ff  <= res_target_ff;
         rsp_trigger_ff <= res_trigger_ff;
         rsp_retune_ff  <= res_retune_ff;
         rsp_vidx_ff    <= res_vidx_ff;
         rsp_vnote_ff   <= res_vnote_ff;
         rsp_dropped_ff <= res_dropped_ff;
         rsp_bend_ff    <= bend_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         stack_mem[mem_waddr] <= mem_wdata;
      end
      if (mem_re) begin
         rdata_ff <= stack_mem[mem_raddr];
      end
   end

   assign out_target      = rsp_target_ff;
   assign out_trigger     = rsp_trigger_ff;
   assign out_retune      = rsp_retune_ff;
   assign out_voice_index = rsp_vidx_ff;
   assign out_voice_note  = rsp_vnote_ff;
   assign out_dropped     = rsp_dropped_ff;
   assign out_bend        = rsp_bend_ff;

endmodule

// ----- rtl/mva_controller.sv -----
`timescale 1ns / 1ps

module mva_controller (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   input  mva_pkg::mva_status_type status,
   output mva_pkg::mva_cmd_type    cmd
);
   import mva_pkg::*;

   typedef enum logic [3:0] {
      S_IDLE,
      S_DISPATCH,
      S_BCAST,
      S_REDUCE,
      S_RR_SCAN,
      S_OFF_SCAN,
      S_POLY_SET,
      S_PUSH,
      S_SRCH_RD,
      S_SRCH_CMP,
      S_SH_RD,
      S_SH_WR,
      S_TOP_RD,
      S_TOP_SET,
      S_V0_COMMIT,
      S_FINISH
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      cmd.action   = DP_NONE;

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.action = DP_LOAD;
               state_in   = S_DISPATCH;
            end
         end
         S_DISPATCH: begin
            priority if (status.op == OP_ALL_OFF || status.op == OP_PITCH_WHEEL) begin
               state_in = S_BCAST;
            end else if (status.mono) begin
               state_in = (status.op == OP_NOTE_ON) ? S_PUSH : S_SRCH_RD;
            end else if (status.op == OP_NOTE_ON) begin
               state_in = S_REDUCE;
            end else begin
               state_in = S_OFF_SCAN;
            end
         end
         S_BCAST: begin
            cmd.action = DP_BCAST;
            state_in   = S_FINISH;
         end
         S_REDUCE: begin
            // the pointer may sit beyond a voice count that was lowered
            if (status.idx_ge_nv) begin
               cmd.action = DP_REDUCE;
            end else begin
               state_in = S_RR_SCAN;
            end
         end
         S_RR_SCAN: begin
            priority if (status.scan_silent) begin
               cmd.action = DP_RR_HIT;
               state_in   = status.sel_zero ? S_PUSH : S_POLY_SET;
            end else if (status.scan_last) begin
               cmd.action = DP_MISS;
               state_in   = S_FINISH;
            end else begin
               cmd.action = DP_SCAN_NEXT;
            end
         end
         S_OFF_SCAN: begin
            priority if (status.scan_match) begin
               state_in = status.sel_zero ? S_SRCH_RD : S_POLY_SET;
            end else if (status.scan_last) begin
               cmd.action = DP_MISS;
               state_in   = S_FINISH;
            end else begin
               cmd.action = DP_SCAN_NEXT;
            end
         end
         S_POLY_SET: begin
            cmd.action = DP_POLY_SET;
            state_in   = S_FINISH;
         end
         S_PUSH: begin
            cmd.action = DP_PUSH;
            state_in   = S_V0_COMMIT;
         end
         S_SRCH_RD: begin
            if (status.stack_empty) begin
               cmd.action = DP_V0_MISS;
               state_in   = S_V0_COMMIT;
            end else begin
               cmd.action = DP_SRCH_RD;
               state_in   = S_SRCH_CMP;
            end
         end
         S_SRCH_CMP: begin
            priority if (status.rd_match) begin
               state_in = S_SH_RD;
            end else if (status.srch_last) begin
               cmd.action = DP_V0_MISS;
               state_in   = S_V0_COMMIT;
            end else begin
               cmd.action = DP_SP_INC;
               state_in   = S_SRCH_RD;
            end
         end
         S_SH_RD: begin
            // close the gap one entry at a time, then drop the count
            if (status.shift_more) begin
               cmd.action = DP_SH_RD;
               state_in   = S_SH_WR;
            end else begin
               cmd.action = DP_POP;
               state_in   = S_TOP_RD;
            end
         end
         S_SH_WR: begin
            cmd.action = DP_SH_WR;
            state_in   = S_SH_RD;
         end
         S_TOP_RD: begin
            if (status.stack_empty) begin
               cmd.action = DP_TOP_EMPTY;
               state_in   = S_V0_COMMIT;
            end else begin
               cmd.action = DP_TOP_RD;
               state_in   = S_TOP_SET;
            end
         end
         S_TOP_SET: begin
            cmd.action = DP_TOP_SET;
            state_in   = S_V0_COMMIT;
         end
         S_V0_COMMIT: begin
            cmd.action = DP_V0_COMMIT;
            state_in   = S_FINISH;
         end
         S_FINISH: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.action   = DP_OUT;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule
